// ----- rtl/hmrg_pkg.sv -----
// Shared types, operation codes and the pointer factor function of the
// HID mouse move report generator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hmrg_pkg;

    // Width of the pointer factor in units of 1/32 (largest value is 160).
    localparam int FACTOR_W = 8;

    // Operation codes of an input word.
    localparam logic [1:0] OP_MOVE        = 2'd0;
    localparam logic [1:0] OP_PRESS       = 2'd1;
    localparam logic [1:0] OP_RELEASE     = 2'd2;
    localparam logic [1:0] OP_RELEASE_ALL = 2'd3;

    // Configuration register indexes.
    localparam int          CFG_IDX_W       = 1;
    localparam logic [0:0]  REG_SENSITIVITY = 1'd0;
    localparam logic [0:0]  REG_PRECISION   = 1'd1;

    // Precision modes; the other codes fall back to a factor of 1.0.
    localparam logic [1:0] PREC_TABLE   = 2'd0;
    localparam logic [1:0] PREC_QUARTER = 2'd1;

    localparam logic [FACTOR_W-1:0] FACTOR_UNITY = 8'd32;

    localparam logic [FACTOR_W-1:0] FACTOR_TABLE [21] = '{
        8'd0,  8'd1,  8'd2,  8'd4,  8'd8,  8'd12, 8'd16, 8'd20, 8'd24, 8'd28, 8'd32,
        8'd40, 8'd48, 8'd56, 8'd64, 8'd72, 8'd80, 8'd88, 8'd96, 8'd104, 8'd112
    };

    // What one axis lane hands to the merging stage.
    typedef struct packed {
        logic signed [7:0] speed;  // signed axis speed
        logic              near;   // axis offset magnitude is at most 3
        logic [3:0]        sq;     // square of the low two magnitude bits
    } lane_res_t;

    // One result word.
    typedef struct packed {
        logic              send_report;
        logic [2:0]        report_buttons;
        logic signed [7:0] report_dx;
        logic signed [7:0] report_dy;
        logic              arrived;
    } report_t;

    function automatic logic [FACTOR_W-1:0] pointer_factor(input logic [4:0] sens,
                                                           input logic [1:0] mode);
        logic                in_range;
        logic [FACTOR_W-1:0] f;
        in_range = (sens >= 5'd1) && (sens <= 5'd20);
        f = FACTOR_UNITY;
        if (in_range && mode == PREC_QUARTER) begin
            f = {sens, 3'b000};
        end else if (in_range && mode == PREC_TABLE) begin
            f = FACTOR_TABLE[sens];
        end
        return f;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/hmrg_axis_lane.sv -----
// One axis lane: offset, clamp to the saturation distance and a
// bit-per-cycle division by the pointer factor. Depends on hmrg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hmrg_axis_lane #(
    parameter int SPEED_MAX = 127
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [15:0]                 current_pos,
    input  logic signed [15:0]                 target_pos,
    input  logic [hmrg_pkg::FACTOR_W-1:0]      factor,
    output logic                               done,
    output hmrg_pkg::lane_res_t                result
);

    localparam int QW   = $clog2(SPEED_MAX + 1);
    localparam int PW   = hmrg_pkg::FACTOR_W + QW;
    localparam int MW   = PW - 5;
    localparam int CMPW = (MW > 16) ? MW : 16;
    localparam int CW   = (QW > 1) ? $clog2(QW) : 1;

    logic signed [16:0] diff_reg;
    logic               prep_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [CW-1:0]      cnt_reg;
    logic [PW-1:0]      rem_reg;
    logic [QW-1:0]      quo_reg;
    logic               neg_reg;
    logic               fz_reg;
    logic               near_reg;
    logic [3:0]         sq_reg;

    logic [16:0]   abs_val;
    logic [15:0]   mag;
    logic [PW-1:0] prod;
    logic [MW-1:0] maxd;
    logic [MW-1:0] clamped;
    logic [PW-1:0] numer;
    logic [PW-1:0] dsh;
    logic [7:0]    s8;

    always_comb begin
        abs_val = diff_reg[16] ? (17'd0 - diff_reg) : diff_reg;
        mag     = abs_val[15:0];
        prod    = PW'(factor) * PW'(SPEED_MAX);
        maxd    = prod[PW-1:5];
        if (CMPW'(mag) > CMPW'(maxd)) begin
            clamped = maxd;
        end else begin
            clamped = MW'(mag);
        end
        if (factor == '0) begin
            numer = '0;
        end else begin
            numer = {clamped, 5'b00000} + PW'(factor) - PW'(1);
        end
        dsh = PW'(factor) << cnt_reg;
        s8  = 8'(quo_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_reg <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                prep_reg <= 1'b1;
                busy_reg <= 1'b1;
            end else if (prep_reg) begin
                prep_reg <= 1'b0;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            diff_reg <= 17'(target_pos) - 17'(current_pos);
        end else if (prep_reg) begin
            rem_reg  <= numer;
            quo_reg  <= '0;
            cnt_reg  <= CW'(QW - 1);
            neg_reg  <= diff_reg[16];
            fz_reg   <= (factor == '0);
            near_reg <= (mag <= 16'd3);
            sq_reg   <= {2'b00, mag[1:0]} * {2'b00, mag[1:0]};
        end else if (busy_reg) begin
            // Restoring division, one quotient bit per cycle, MSB first.
            if (rem_reg >= dsh) begin
                rem_reg <= rem_reg - dsh;
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end else begin
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
            if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_comb begin
        if (fz_reg) begin
            result.speed = '0;
        end else if (neg_reg) begin
            result.speed = 8'd0 - s8;
        end else begin
            result.speed = s8;
        end
        result.near = near_reg;
        result.sq   = sq_reg;
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ----- rtl/hmrg_merge.sv -----
// Merging stage: combines both axis lanes into the arrival test and the
// move report, and applies button operations. Depends on hmrg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hmrg_merge (
    input  logic [1:0]          operation,
    input  logic [2:0]          button,
    input  logic                observed_down,
    input  logic [2:0]          held,
    input  hmrg_pkg::lane_res_t lane_x,
    input  hmrg_pkg::lane_res_t lane_y,
    output logic [2:0]          held_next,
    output hmrg_pkg::report_t   report
);

    logic [4:0] dist_sq;
    logic       close;

    always_comb begin
        dist_sq = {1'b0, lane_x.sq} + {1'b0, lane_y.sq};
        close   = lane_x.near && lane_y.near && (dist_sq <= 5'd9);

        held_next             = held;
        report.send_report    = 1'b0;
        report.report_dx      = '0;
        report.report_dy      = '0;
        report.arrived        = 1'b0;

        case (operation)
            hmrg_pkg::OP_MOVE: begin
                if (close) begin
                    report.arrived = 1'b1;
                end else begin
                    report.send_report = 1'b1;
                    report.report_dx   = lane_x.speed;
                    report.report_dy   = lane_y.speed;
                end
            end
            hmrg_pkg::OP_PRESS: begin
                if (!observed_down) begin
                    held_next          = held | button;
                    report.send_report = 1'b1;
                end
            end
            hmrg_pkg::OP_RELEASE: begin
                if (observed_down) begin
                    held_next          = held & ~button;
                    report.send_report = 1'b1;
                end
            end
            default: begin
                if (observed_down) begin
                    held_next          = 3'b000;
                    report.send_report = 1'b1;
                end
            end
        endcase

        report.report_buttons = held_next;
    end

endmodule

`default_nettype wire

// ----- rtl/hid_mouse_move_report_generator_top.sv -----
// Top level of the HID mouse move report generator: handshakes, config
// registers, two axis lanes and the merging stage. Depends on hmrg_pkg.
//
// Usage: an input word (s_ channel, valid/ready) carries one operation: a
// move step with current and target positions, a press, a release or a
// release-all. Every word yields exactly one result word on the m_ channel.
// A move step drives the x and y lanes side by side; each lane clamps its
// offset and divides by the pointer factor one quotient bit per cycle.
// With SPEED_MAX at 127, the offsets are registered at the edge that
// accepts the input word; then the lane clamps and sets up the divider,
// seven divider steps follow (the bit count of SPEED_MAX), the lane raises
// done, the sequencer enters its hold state and the output register is
// loaded, raising m_valid. Button operations take the same path and the
// same time. One word is in flight at a time and s_ready returns at the
// edge that loads the output register, so a new word is taken only once
// the last one is finished.
// The output register holds a finished word while the receiver stalls, and
// the next input word is already accepted and computed meanwhile; it waits
// in the lanes until the output register frees up.
// Reset (aresetn low, synchronous) clears the held button mask, sets
// sensitivity to 10 and precision mode to 1, and empties the output.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at once
// and must only be issued while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module hid_mouse_move_report_generator_top #(
    parameter int SPEED_MAX = 127
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_wr_en,
    input  logic [hmrg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [4:0]                     cfg_data,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_operation,
    input  logic [2:0]                     s_button,
    input  logic                           s_observed_down,
    input  logic signed [15:0]             s_current_x,
    input  logic signed [15:0]             s_current_y,
    input  logic signed [15:0]             s_target_x,
    input  logic signed [15:0]             s_target_y,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_send_report,
    output logic [2:0]                     m_report_buttons,
    output logic signed [7:0]              m_report_dx,
    output logic signed [7:0]              m_report_dy,
    output logic                           m_arrived
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Configuration registers.
    logic [4:0] sensitivity_reg;
    logic [1:0] precision_mode_reg;
    logic [hmrg_pkg::FACTOR_W-1:0] factor;

    // Operation fields captured at acceptance.
    logic [1:0] op_reg;
    logic [2:0] button_reg;
    logic       seen_reg;

    logic [2:0] held_buttons_reg;
    logic [2:0] held_buttons_next;

    logic               m_valid_reg;
    hmrg_pkg::report_t  out_reg;
    hmrg_pkg::report_t  merged;

    hmrg_pkg::lane_res_t lane_x_res;
    hmrg_pkg::lane_res_t lane_y_res;
    logic                lane_x_done;
    logic                lane_y_done;

    logic in_fire;
    logic out_free;
    logic load_out;

    assign factor   = hmrg_pkg::pointer_factor(sensitivity_reg, precision_mode_reg);
    assign s_ready  = (state_reg == ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (state_reg == ST_HOLD) && out_free;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sensitivity_reg    <= 5'd10;
            precision_mode_reg <= 2'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                hmrg_pkg::REG_SENSITIVITY: sensitivity_reg    <= cfg_data;
                hmrg_pkg::REG_PRECISION:   precision_mode_reg <= cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg     <= s_operation;
            button_reg <= s_button;
            seen_reg   <= s_observed_down;
        end
    end

    // Both lanes start together and take the same number of cycles.
    hmrg_axis_lane #(
        .SPEED_MAX (SPEED_MAX)
    ) u_lane_x (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (in_fire),
        .current_pos (s_current_x),
        .target_pos  (s_target_x),
        .factor      (factor),
        .done        (lane_x_done),
        .result      (lane_x_res)
    );

    hmrg_axis_lane #(
        .SPEED_MAX (SPEED_MAX)
    ) u_lane_y (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (in_fire),
        .current_pos (s_current_y),
        .target_pos  (s_target_y),
        .factor      (factor),
        .done        (lane_y_done),
        .result      (lane_y_res)
    );

    hmrg_merge u_merge (
        .operation     (op_reg),
        .button        (button_reg),
        .observed_down (seen_reg),
        .held          (held_buttons_reg),
        .lane_x        (lane_x_res),
        .lane_y        (lane_y_res),
        .held_next     (held_buttons_next),
        .report        (merged)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (lane_x_done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            held_buttons_reg <= 3'b000;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                held_buttons_reg <= held_buttons_next;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg      <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= merged;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_send_report    = out_reg.send_report;
    assign m_report_buttons = out_reg.report_buttons;
    assign m_report_dx      = out_reg.report_dx;
    assign m_report_dy      = out_reg.report_dy;
    assign m_arrived        = out_reg.arrived;

    // The two lanes run in lockstep.
    a_lanes_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_x_done == lane_y_done)
        else $error("axis lanes finished in different cycles");

    // A lane only finishes while the sequencer waits for it.
    a_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_x_done |-> (state_reg == ST_CALC))
        else $error("lane finished outside the calculation state");

    // Arrival never comes with a report.
    a_arrived_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_arrived && m_send_report))
        else $error("arrival word also requests a report");

    // Words without a report carry no motion.
    a_idle_motion: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_send_report) |-> (m_report_dx == 8'sd0 && m_report_dy == 8'sd0))
        else $error("motion present on a word without a report");

endmodule

`default_nettype wire
